@@ hw/rtl/rpd_pkg.sv @@
// Shared types and constants of the RNDIS packet deframer.
package rpd_pkg;

  localparam int TB_W = 15;
  localparam int MO_W = 16;
  localparam int WIDE_W = 34;

  localparam logic [MO_W-1:0] HDR_BYTES = MO_W'(44);
  localparam logic [MO_W-1:0] HDR_LAST = MO_W'(43);
  localparam logic [MO_W-1:0] HDR_KEPT = MO_W'(16);
  localparam logic [31:0] MSG_TYPE_PACKET = 32'd1;
  localparam logic [31:0] DATA_OFFSET_BASE = 32'd8;
  localparam logic [31:0] MIN_FRAME_BYTES = 32'd14;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_DROP
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD    = 3'd0,
    EV_SKIPPED    = 3'd1,
    EV_BAD_TYPE   = 3'd2,
    EV_TRUNCATED  = 3'd3,
    EV_SHORT_TAIL = 3'd4
  } event_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [TB_W-1:0] transfer_bytes;
    logic            last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    event_t     event_res;
  } out_item_t;

endpackage

@@ hw/rtl/rpd_ifs.sv @@
// Valid/ready channel interfaces for transfer bytes and frame results.
interface rpd_in_if import rpd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rpd_out_if import rpd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/rndis_packet_deframer_unit.sv @@
// Top level of the RNDIS data-packet deframer.
// Path: a byte's result goes through the input register and then the result register.
// Throughput: one byte per cycle while the sink keeps up, set by the single parse pass
// between the two registers; a full result register with no sink ready stalls the input.
// Reset: synchronous rst clears both registers and the parse state; no clearing pass.
module rndis_packet_deframer_unit import rpd_pkg::*; #(
  parameter int MAX_TRANSFER_BYTES = 16384
) (
  input  logic      clk,
  input  logic      rst,
  rpd_in_if.sink    bytes,
  rpd_out_if.source frames
);

  logic      held_valid;
  in_item_t  held_item;
  logic      room;
  logic      take;
  logic      res_valid;
  out_item_t res;

  assign take = held_valid && room;

  rpd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  rpd_parser #(
    .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  rpd_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (take && res_valid),
    .res    (res),
    .room   (room),
    .frames (frames)
  );

endmodule

@@ hw/rtl/rpd_in_stage.sv @@
// Input register that holds one accepted transfer byte until it is parsed.
module rpd_in_stage import rpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  rpd_in_if.sink   bytes,
  input  logic     take,
  output logic     held_valid,
  output in_item_t held_item
);

  logic     valid_q;
  in_item_t item_q;

  assign bytes.ready = !valid_q || take;
  assign held_valid = valid_q;
  assign held_item = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (bytes.ready) begin
      valid_q <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      item_q <= bytes.data;
    end
  end

endmodule

@@ hw/rtl/rpd_parser.sv @@
// Message walker: header capture, message checks and payload selection.
module rpd_parser import rpd_pkg::*; #(
  parameter int MAX_TRANSFER_BYTES = 16384
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  localparam int CNT_W = $clog2(MAX_TRANSFER_BYTES + 1);
  localparam int LW = (CNT_W > TB_W) ? CNT_W : TB_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TRANSFER_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRANSFER_BYTES);

  logic [CNT_W-1:0] transfer_offset, transfer_offset_next;
  logic [MO_W-1:0]  message_offset, message_offset_next;
  phase_t           parse_phase, parse_phase_next;
  logic             forward_this_message, forward_this_message_next;

  logic [31:0]      hdr_word [4];
  logic [31:0]      hdr_word_next [4];
  logic [LW-1:0]    msg_start, msg_start_next;
  logic [MO_W-1:0]  data_start, data_start_next;
  logic [MO_W-1:0]  data_end, data_end_next;
  logic [MO_W-1:0]  msg_len, msg_len_next;

  logic [LW-1:0]     tb_len;
  logic [LW-1:0]     len;
  logic [LW-1:0]     pos;
  logic              in_range;
  logic              tail_short;
  logic              truncated;
  logic              qualifies;
  logic [WIDE_W-1:0] doff;
  logic [WIDE_W-1:0] dend;
  logic [MO_W-1:0]   m_inc;

  assign tb_len = LW'(item.transfer_bytes);
  assign len = (tb_len > MAX_LEN) ? MAX_LEN : tb_len;
  assign pos = LW'(transfer_offset);
  assign in_range = pos < len;
  assign tail_short = ((LW + 1)'(pos) + (LW + 1)'(HDR_BYTES)) > (LW + 1)'(len);
  assign truncated = (hdr_word[1] < 32'(HDR_BYTES)) ||
                     ((WIDE_W'(msg_start) + WIDE_W'(hdr_word[1])) > WIDE_W'(len));
  assign doff = WIDE_W'(hdr_word[2]) + WIDE_W'(DATA_OFFSET_BASE);
  assign dend = doff + WIDE_W'(hdr_word[3]);
  assign qualifies = (doff >= WIDE_W'(HDR_BYTES)) && (dend <= WIDE_W'(hdr_word[1])) &&
                     (hdr_word[3] >= MIN_FRAME_BYTES);
  assign m_inc = message_offset + MO_W'(1);

  always_comb begin
    transfer_offset_next = transfer_offset;
    message_offset_next = message_offset;
    parse_phase_next = parse_phase;
    forward_this_message_next = forward_this_message;
    hdr_word_next = hdr_word;
    msg_start_next = msg_start;
    data_start_next = data_start;
    data_end_next = data_end;
    msg_len_next = msg_len;
    if (in_range) begin
      unique case (parse_phase)
        PH_HEADER: begin
          if (message_offset == '0 && tail_short) begin
            parse_phase_next = PH_DROP;
          end else begin
            if (message_offset < HDR_KEPT) begin
              hdr_word_next[message_offset[3:2]][8 * message_offset[1:0] +: 8] = item.data_byte;
            end
            if (message_offset == '0) begin
              msg_start_next = pos;
            end
            message_offset_next = m_inc;
            if (message_offset == HDR_LAST) begin
              if (hdr_word[0] != MSG_TYPE_PACKET || truncated) begin
                parse_phase_next = PH_DROP;
              end else begin
                forward_this_message_next = qualifies;
                data_start_next = MO_W'(doff);
                data_end_next = MO_W'(dend);
                msg_len_next = MO_W'(hdr_word[1]);
                if (hdr_word[1] == 32'(HDR_BYTES)) begin
                  message_offset_next = '0;
                  parse_phase_next = PH_HEADER;
                end else begin
                  parse_phase_next = PH_BODY;
                end
              end
            end
          end
        end
        PH_BODY: begin
          message_offset_next = m_inc;
          if (m_inc >= msg_len) begin
            message_offset_next = '0;
            parse_phase_next = PH_HEADER;
          end
        end
        PH_DROP: begin
        end
        default: begin
        end
      endcase
    end
    if (transfer_offset < MAX_CNT) begin
      transfer_offset_next = transfer_offset + CNT_W'(1);
    end
    if (item.last_byte) begin
      transfer_offset_next = '0;
      message_offset_next = '0;
      parse_phase_next = PH_HEADER;
      forward_this_message_next = 1'b0;
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res.frame_byte = 8'd0;
    res.frame_end = 1'b0;
    res.event_res = EV_PAYLOAD;
    if (in_range) begin
      unique case (parse_phase)
        PH_HEADER: begin
          if (message_offset == '0 && tail_short) begin
            res_valid = 1'b1;
            res.event_res = EV_SHORT_TAIL;
          end else if (message_offset == HDR_LAST) begin
            if (hdr_word[0] != MSG_TYPE_PACKET) begin
              res_valid = 1'b1;
              res.event_res = EV_BAD_TYPE;
            end else if (truncated) begin
              res_valid = 1'b1;
              res.event_res = EV_TRUNCATED;
            end else if (!qualifies) begin
              res_valid = 1'b1;
              res.event_res = EV_SKIPPED;
            end
          end
        end
        PH_BODY: begin
          if (forward_this_message && message_offset >= data_start &&
              message_offset < data_end) begin
            res_valid = 1'b1;
            res.frame_byte = item.data_byte;
            res.frame_end = (m_inc == data_end);
          end
        end
        PH_DROP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_offset <= '0;
      message_offset <= '0;
      parse_phase <= PH_HEADER;
      forward_this_message <= 1'b0;
    end else if (take) begin
      transfer_offset <= transfer_offset_next;
      message_offset <= message_offset_next;
      parse_phase <= parse_phase_next;
      forward_this_message <= forward_this_message_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hdr_word <= hdr_word_next;
      msg_start <= msg_start_next;
      data_start <= data_start_next;
      data_end <= data_end_next;
      msg_len <= msg_len_next;
    end
  end

endmodule

@@ hw/rtl/rpd_out_stage.sv @@
// Result register that holds one result until the sink takes it.
module rpd_out_stage import rpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t res,
  output logic      room,
  rpd_out_if.source frames
);

  logic      valid_q;
  out_item_t item_q;

  assign room = !valid_q || frames.ready;
  assign frames.valid = valid_q;
  assign frames.data = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (frames.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= res;
    end
  end

endmodule
